// File: design/mvrps_pkg.sv
// Shared types, constants and codes of the MPEG video RTP packet splitter.
package mvrps_pkg;

  localparam int unsigned MaxChunkBytes = 16384;
  localparam int unsigned MaxResults    = 33;
  localparam int unsigned LenW          = 14;
  localparam int unsigned MtuW          = 16;
  localparam int unsigned FlagsW        = 4;
  localparam int unsigned CntW          = $clog2(MaxResults + 1);

  localparam logic [MtuW-1:0] MtuReset = 16'd3048;
  localparam logic [MtuW-1:0] MtuFloor = 16'd512;
  localparam logic [LenW-1:0] LenMax   = LenW'(MaxChunkBytes - 1);

  // Bit positions in the seen flags
  localparam int unsigned FlagSeq  = 0;
  localparam int unsigned FlagGop  = 1;
  localparam int unsigned FlagPic  = 2;
  localparam int unsigned FlagData = 3;

  // Start codes
  localparam logic [7:0] CodePic = 8'h00;
  localparam logic [7:0] CodeSeq = 8'hB3;
  localparam logic [7:0] CodeGop = 8'hB8;
  localparam logic [7:0] SliceLo = 8'h01;
  localparam logic [7:0] SliceHi = 8'hAF;

  localparam logic OpChunk = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [7:0]      start_code;
    logic [LenW-1:0] chunk_length;
  } in_item_t;

  typedef struct packed {
    logic            send_before;
    logic [LenW-1:0] byte_offset;
    logic [LenW-1:0] byte_count;
    logic            send_after;
    logic            last;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_FRAG
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic needs_frag;
    logic frag_last;
  } status_t;

endpackage

// File: design/mvrps_ctrl.sv
// Controller: input and output handshake and fragment sequencing.
module mvrps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mvrps_pkg::status_t status_i,
  output mvrps_pkg::cmd_t    cmd_o
);

  mvrps_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mvrps_pkg::ST_IDLE: begin
        if (in_valid_i && slot_free && status_i.needs_frag) begin
          state_d = mvrps_pkg::ST_FRAG;
        end
      end
      mvrps_pkg::ST_FRAG: begin
        if (slot_free && status_i.frag_last) begin
          state_d = mvrps_pkg::ST_IDLE;
        end
      end
      default: state_d = mvrps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      mvrps_pkg::ST_IDLE: begin
        in_ready_o = slot_free;
        cmd_o.load = in_valid_i && slot_free;
      end
      mvrps_pkg::ST_FRAG: begin
        cmd_o.step = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
        cmd_o      = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load || cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvrps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/mvrps_datapath.sv
// Datapath: packet state, mtu register, segment planning and output word.
module mvrps_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mvrps_pkg::in_item_t           in_data_i,
  input  mvrps_pkg::cmd_t               cmd_i,
  output mvrps_pkg::status_t            status_o,
  output mvrps_pkg::out_item_t          out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mvrps_pkg::MtuW-1:0]    cfg_data_i
);

  localparam int unsigned LenW   = mvrps_pkg::LenW;
  localparam int unsigned MtuW   = mvrps_pkg::MtuW;
  localparam int unsigned FlagsW = mvrps_pkg::FlagsW;
  localparam int unsigned CntW   = mvrps_pkg::CntW;

  // Packet state
  logic [MtuW-1:0]   mtu_q, mtu_d;
  logic              open_q, open_d;
  logic [FlagsW-1:0] flags_q, flags_d;
  logic [MtuW-1:0]   room_q, room_d;

  // Fragment walk and output word
  logic [LenW-1:0]      rem_q, rem_d;
  logic [LenW-1:0]      off_q, off_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  mvrps_pkg::out_item_t out_q, out_d;

  logic [MtuW-1:0]   umtu;
  logic [LenW-1:0]   len;
  logic [MtuW-1:0]   len_w;
  logic              is_seq, is_gop, is_pic, is_slice;
  logic              sb_pre;
  logic [FlagsW-1:0] flags_pre;
  logic [MtuW-1:0]   room_pre;
  logic              fits_room, fits_mtu, frag_ld;
  logic              first_sb;
  logic [LenW-1:0]   first_cnt;
  logic [LenW-1:0]   step_cnt;
  logic [LenW-1:0]   step_rem;
  logic              step_last;

  assign umtu  = (mtu_q < mvrps_pkg::MtuFloor) ? mvrps_pkg::MtuFloor : mtu_q;
  assign len   = (in_data_i.chunk_length > mvrps_pkg::LenMax) ? mvrps_pkg::LenMax
                                                              : in_data_i.chunk_length;
  assign len_w = MtuW'(len);

  assign is_seq   = (in_data_i.start_code == mvrps_pkg::CodeSeq);
  assign is_gop   = (in_data_i.start_code == mvrps_pkg::CodeGop);
  assign is_pic   = (in_data_i.start_code == mvrps_pkg::CodePic);
  assign is_slice = (in_data_i.start_code >= mvrps_pkg::SliceLo) &&
                    (in_data_i.start_code <= mvrps_pkg::SliceHi);

  // Header handling ahead of the append decision
  always_comb begin
    sb_pre    = 1'b0;
    flags_pre = flags_q;
    room_pre  = room_q;
    if (is_seq) begin
      sb_pre    = open_q;
      flags_pre = '0;
      flags_pre[mvrps_pkg::FlagSeq] = 1'b1;
      room_pre  = umtu;
    end else begin
      if (!open_q) begin
        flags_pre = '0;
        room_pre  = umtu;
      end
      if (is_gop || is_pic) begin
        if (flags_pre[mvrps_pkg::FlagData]) begin
          sb_pre    = 1'b1;
          flags_pre = '0;
          room_pre  = umtu;
        end
        if (is_gop) begin
          flags_pre[mvrps_pkg::FlagGop] = 1'b1;
        end else begin
          flags_pre[mvrps_pkg::FlagPic] = 1'b1;
        end
      end
    end
  end

  assign fits_room = (len_w <= room_pre);
  assign fits_mtu  = (len_w <= umtu);
  assign frag_ld   = (in_data_i.operation == mvrps_pkg::OpChunk) && is_slice &&
                     !fits_room && !fits_mtu;

  // First fragment: a full packet goes out first so no fragment is empty
  assign first_sb  = (room_pre == '0);
  assign first_cnt = first_sb ? umtu[LenW-1:0] : room_pre[LenW-1:0];

  assign step_cnt  = (MtuW'(rem_q) > umtu) ? umtu[LenW-1:0] : rem_q;
  assign step_rem  = rem_q - step_cnt;
  assign step_last = (step_rem == '0) ||
                     (cnt_q == CntW'(mvrps_pkg::MaxResults - 1));

  assign status_o.needs_frag = frag_ld;
  assign status_o.frag_last  = step_last;

  always_comb begin
    mtu_d   = cfg_we_i ? cfg_data_i : mtu_q;
    open_d  = open_q;
    flags_d = flags_q;
    room_d  = room_q;
    rem_d   = rem_q;
    off_d   = off_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      out_d = '0;
      out_d.last = 1'b1;
      if (in_data_i.operation == mvrps_pkg::OpFlush) begin
        out_d.send_before = open_q;
        open_d  = 1'b0;
        flags_d = '0;
        room_d  = umtu;
      end else if (is_slice) begin
        open_d = 1'b1;
        if (fits_room) begin
          out_d.byte_count = len;
          room_d  = room_pre - len_w;
          flags_d = flags_pre;
          flags_d[mvrps_pkg::FlagData] = 1'b1;
        end else if (fits_mtu) begin
          out_d.send_before = 1'b1;
          out_d.byte_count  = len;
          room_d  = umtu - len_w;
          flags_d = '0;
          flags_d[mvrps_pkg::FlagData] = 1'b1;
        end else begin
          out_d.send_before = first_sb;
          out_d.byte_count  = first_cnt;
          out_d.send_after  = 1'b1;
          out_d.last        = 1'b0;
          rem_d   = len - first_cnt;
          off_d   = first_cnt;
          cnt_d   = CntW'(1);
          flags_d = '0;
          room_d  = umtu;
        end
      end else begin
        out_d.send_before = sb_pre;
        out_d.byte_count  = len;
        open_d  = 1'b1;
        flags_d = flags_pre;
        room_d  = (room_pre > len_w) ? room_pre - len_w : '0;
      end
    end else if (cmd_i.step) begin
      out_d.send_before = 1'b0;
      out_d.byte_offset = off_q;
      out_d.byte_count  = step_cnt;
      out_d.send_after  = 1'b1;
      out_d.last        = step_last;
      rem_d = step_rem;
      off_d = off_q + step_cnt;
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q   <= mvrps_pkg::MtuReset;
      open_q  <= 1'b0;
      flags_q <= '0;
      room_q  <= mvrps_pkg::MtuReset;
    end else begin
      mtu_q   <= mtu_d;
      open_q  <= open_d;
      flags_q <= flags_d;
      room_q  <= room_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    off_q <= off_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// File: design/mpeg_video_rtp_packet_splitter.sv
// Top level of the MPEG video RTP packet splitter.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i  | out_data_o (out_item_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i (mtu, 16 bit)
//
// A chunk or flush with one result is loaded straight into the output register; the next
// word can be taken as soon as the output slot is free. A slice split into N fragments
// (N up to 33) is stepped out one fragment per cycle while out_ready_i allows.
// Reset restores mtu and room to 3048 and closes the packet; no clearing pass.
// While out_ready_i is low the output register holds and the stepper waits.
module mpeg_video_rtp_packet_splitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mvrps_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mvrps_pkg::out_item_t          out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mvrps_pkg::MtuW-1:0]    cfg_data_i
);

  mvrps_pkg::cmd_t    cmd;
  mvrps_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  mvrps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mvrps_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // A flush yields exactly one empty, final word
  a_flush_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.operation == mvrps_pkg::OpFlush)
    |=> out_valid_o && out_data_o.last && (out_data_o.byte_count == '0) &&
        !out_data_o.send_after)
    else $error("flush did not give a single empty final word");

  // Fragments are never empty
  a_frag_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_after |-> (out_data_o.byte_count != '0))
    else $error("empty fragment");

  // No new word is taken while fragments are still being stepped out
  a_no_accept_in_frag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !in_ready_o && !cmd.load)
    else $error("input accepted during fragmenting");

endmodule

// File: tb/mpeg_video_rtp_packet_splitter_test.sv
// Self-checking testbench for the MPEG video RTP packet splitter.
module mpeg_video_rtp_packet_splitter_test;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseWords = 46;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned LenW       = mvrps_pkg::LenW;
  localparam int unsigned MtuW       = mvrps_pkg::MtuW;

  // Plans the packet segments of every accepted word and checks the block's results.
  class packet_plan_board;
    int unsigned          mtu_reg;
    bit                   pkt_open;
    bit [3:0]             seen;
    int unsigned          room;
    mvrps_pkg::out_item_t planned[$];
    int unsigned          faults;

    function new();
      mtu_reg  = mvrps_pkg::MtuReset;
      pkt_open = 1'b0;
      seen     = '0;
      room     = mvrps_pkg::MtuReset;
      faults   = 0;
    endfunction

    function int unsigned eff_mtu();
      return (mtu_reg < mvrps_pkg::MtuFloor) ? mvrps_pkg::MtuFloor : mtu_reg;
    endfunction

    // Open an empty packet; report whether one was already open and must go out.
    function bit open_fresh();
      bit was_open;
      was_open = pkt_open;
      pkt_open = 1'b1;
      seen     = '0;
      room     = eff_mtu();
      return was_open;
    endfunction

    function void push(bit sb, int unsigned off, int unsigned cnt, bit sa, bit lst);
      mvrps_pkg::out_item_t seg;
      seg.send_before = sb;
      seg.byte_offset = LenW'(off);
      seg.byte_count  = LenW'(cnt);
      seg.send_after  = sa;
      seg.last        = lst;
      planned.push_back(seg);
    endfunction

    function void note_word(mvrps_pkg::in_item_t w);
      int unsigned len, m, off, c, n;
      bit          sb, b;
      if (w.operation == mvrps_pkg::OpFlush) begin
        sb       = pkt_open;
        pkt_open = 1'b0;
        seen     = '0;
        room     = eff_mtu();
        push(sb, 0, 0, 1'b0, 1'b1);
        return;
      end
      len = w.chunk_length;
      if (len > mvrps_pkg::LenMax) len = mvrps_pkg::LenMax;
      sb = 1'b0;
      if (w.start_code == mvrps_pkg::CodeSeq) begin
        sb = open_fresh();
        seen[mvrps_pkg::FlagSeq] = 1'b1;
      end else begin
        if (!pkt_open) void'(open_fresh());
        if (w.start_code == mvrps_pkg::CodeGop || w.start_code == mvrps_pkg::CodePic) begin
          if (seen[mvrps_pkg::FlagData]) sb = open_fresh();
          if (w.start_code == mvrps_pkg::CodeGop) seen[mvrps_pkg::FlagGop] = 1'b1;
          else seen[mvrps_pkg::FlagPic] = 1'b1;
        end
      end
      if (w.start_code >= mvrps_pkg::SliceLo && w.start_code <= mvrps_pkg::SliceHi) begin
        m = eff_mtu();
        if (len <= room) begin
          room -= len;
          seen[mvrps_pkg::FlagData] = 1'b1;
          push(1'b0, 0, len, 1'b0, 1'b1);
        end else if (len <= m) begin
          // move the slice to a packet of its own
          b    = open_fresh();
          room = m - len;
          seen = '0;
          seen[mvrps_pkg::FlagData] = 1'b1;
          push(b, 0, len, 1'b0, 1'b1);
        end else begin
          off = 0;
          n   = 0;
          while (len > 0 && n < mvrps_pkg::MaxResults) begin
            b = 1'b0;
            if (room == 0) b = open_fresh();
            c = (room < len) ? room : len;
            n++;
            push(b, off, c, 1'b1, (c == len) || (n == mvrps_pkg::MaxResults));
            off += c;
            len -= c;
            void'(open_fresh());
          end
        end
      end else begin
        room = (room > len) ? room - len : 0;
        push(sb, 0, len, 1'b0, 1'b1);
      end
    endfunction

    function void check_word(mvrps_pkg::out_item_t got);
      mvrps_pkg::out_item_t want;
      if (planned.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected segment: sb=%0d off=%0d cnt=%0d sa=%0d last=%0d",
                   got.send_before, got.byte_offset, got.byte_count,
                   got.send_after, got.last);
        return;
      end
      want = planned.pop_front();
      if (got.send_before !== want.send_before || got.byte_offset !== want.byte_offset ||
          got.byte_count !== want.byte_count || got.send_after !== want.send_after ||
          got.last !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("segment mismatch, expected: sb=%0d off=%0d cnt=%0d sa=%0d last=%0d",
                   want.send_before, want.byte_offset, want.byte_count,
                   want.send_after, want.last);
          $display("                  actual:   sb=%0d off=%0d cnt=%0d sa=%0d last=%0d",
                   got.send_before, got.byte_offset, got.byte_count,
                   got.send_after, got.last);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  mvrps_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  mvrps_pkg::out_item_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [MtuW-1:0]      cfg_data;

  packet_plan_board board = new();
  bit               quiet;
  int unsigned      cycles;

  mpeg_video_rtp_packet_splitter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("mpeg_video_rtp_packet_splitter_test: FAIL");
      $finish;
    end
  end

  function automatic int unsigned pause_len();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic mvrps_pkg::in_item_t mk(logic op, logic [7:0] code,
                                             logic [LenW-1:0] len);
    mvrps_pkg::in_item_t w;
    w.operation    = op;
    w.start_code   = code;
    w.chunk_length = len;
    return w;
  endfunction

  function automatic logic [LenW-1:0] slice_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 9) return LenW'($urandom_range(0, 600));
    if (r < 14) return LenW'($urandom_range(0, 3100));
    if (r < 17) return LenW'($urandom);
    if (r < 19) return LenW'($urandom_range(3000, mvrps_pkg::LenMax));
    return ($urandom_range(0, 1) != 0) ? mvrps_pkg::LenMax : '0;
  endfunction

  function automatic mvrps_pkg::in_item_t random_word();
    mvrps_pkg::in_item_t w;
    int unsigned         r;
    logic [LenW-1:0]     hdr_len;
    hdr_len = ($urandom_range(0, 3) == 0) ? LenW'($urandom) : LenW'($urandom_range(0, 300));
    r = $urandom_range(0, 99);
    if (r < 5) w = mk(mvrps_pkg::OpFlush, 8'($urandom), LenW'($urandom));
    else if (r < 12) w = mk(mvrps_pkg::OpChunk, mvrps_pkg::CodeSeq, hdr_len);
    else if (r < 18) w = mk(mvrps_pkg::OpChunk, mvrps_pkg::CodeGop, hdr_len);
    else if (r < 28) w = mk(mvrps_pkg::OpChunk, mvrps_pkg::CodePic, hdr_len);
    else if (r < 78) w = mk(mvrps_pkg::OpChunk,
                            8'($urandom_range(mvrps_pkg::SliceLo, mvrps_pkg::SliceHi)),
                            slice_len());
    else if (r < 90) w = mk(mvrps_pkg::OpChunk, 8'($urandom_range(8'hB0, 8'hFF)), hdr_len);
    else w = mk(1'($urandom), 8'($urandom), LenW'($urandom));
    return w;
  endfunction

  task automatic send_word(mvrps_pkg::in_item_t w);
    int unsigned gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
  endtask

  // Hold the sender until every planned segment has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.planned.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mtu(logic [MtuW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.mtu_reg = value;
  endtask

  // Result side: random stalls, check every word taken.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pause_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_word(out_data);
    end
  end

  initial begin
    logic [MtuW-1:0] mtu_steps[NumPhases];
    quiet     = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    mtu_steps = '{16'd512, 16'hFFFF, 16'd0, 16'd1500, 16'd511, 16'd3048, 16'd0};
    mtu_steps[NumPhases-1] = 16'($urandom_range(512, 65535));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset mtu
    send_word(mk(mvrps_pkg::OpFlush, 8'hFF, mvrps_pkg::LenMax));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::CodeSeq, 14'd12));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::CodeGop, 14'd8));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::CodePic, 14'd8));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::SliceLo, 14'd100));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::SliceHi, 14'd2950));
    send_word(mk(mvrps_pkg::OpChunk, 8'h02, 14'd98));
    send_word(mk(mvrps_pkg::OpChunk, 8'h03, 14'd0));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::CodePic, 14'd0));
    send_word(mk(mvrps_pkg::OpChunk, 8'hB5, 14'd20));
    send_word(mk(mvrps_pkg::OpChunk, 8'h10, 14'd3048));
    send_word(mk(mvrps_pkg::OpChunk, 8'hB2, 14'd5000));
    send_word(mk(mvrps_pkg::OpChunk, 8'h20, mvrps_pkg::LenMax));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::CodeGop, 14'd0));
    send_word(mk(mvrps_pkg::OpChunk, 8'h30, 14'd3040));
    send_word(mk(mvrps_pkg::OpChunk, 8'h31, mvrps_pkg::LenMax));
    send_word(mk(mvrps_pkg::OpChunk, 8'hB7, 14'd4));
    send_word(mk(mvrps_pkg::OpFlush, 8'h00, 14'd0));
    send_word(mk(mvrps_pkg::OpFlush, 8'hB3, 14'd7));
    send_word(mk(mvrps_pkg::OpChunk, 8'h7F, 14'h2AAA));
    send_word(mk(mvrps_pkg::OpChunk, 8'hFF, 14'h1555));
    send_word(mk(mvrps_pkg::OpChunk, mvrps_pkg::CodeSeq, mvrps_pkg::LenMax));
    send_word(mk(mvrps_pkg::OpChunk, 8'hB0, 14'd1));
    send_word(mk(mvrps_pkg::OpFlush, 8'h55, 14'h2AAA));

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_mtu(mtu_steps[p]);
      for (int k = 0; k < PhaseWords; k++) begin
        quiet = (p == 2) || (k >= 20 && k < 30);
        send_word(random_word());
      end
    end

    quiet = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (board.faults == 0 && board.planned.size() == 0) begin
      $display("mpeg_video_rtp_packet_splitter_test: PASS");
    end else begin
      $display("mpeg_video_rtp_packet_splitter_test: FAIL");
    end
    $finish;
  end

endmodule
